@@ hdl/best_fit_aligned_segment_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// allocator assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_ALIGNED_SEGMENT_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_ALIGNED_SEGMENT_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define BFASA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BFASA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define BFASA_ASSERT(lbl, clk, rstn, prop, msg)
`define BFASA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ hdl/bfasa_pkg.sv @@
// ----------------------------------------------------------------------------
// allocator package
// sizes, codes and shared types of the segment allocator
// ----------------------------------------------------------------------------
`default_nettype none
package bfasa_pkg;
    localparam int BLOCK_BYTES  = 65536;
    localparam int MAX_BLOCKS   = 8;
    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_IW       = $clog2(MAX_SEGMENTS);
    localparam int BO_W         = $clog2(MAX_BLOCKS + 1);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_NO_BLOCK   = 2'd2,
        ST_TABLE_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  blk;
        logic [15:0] start;
        logic [16:0] len;
    } t_seg;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic wr0;
        logic wr1;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last_issued;
    } t_stat;
endpackage
`default_nettype wire

@@ hdl/bfasa_ram.sv @@
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module bfasa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ hdl/bfasa_datapath.sv @@
// ----------------------------------------------------------------------------
// allocator datapath
// segment table, scan evaluation, update planning and result registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_aligned_segment_allocator_assert.svh"
module bfasa_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire bfasa_pkg::t_cmd     i_cmd,
    output bfasa_pkg::t_stat         o_stat,
    input  wire logic                i_req_type,
    input  wire logic [16:0]         i_req_size,
    input  wire logic [4:0]          i_req_align_log2,
    input  wire logic [2:0]          i_req_block,
    input  wire logic [15:0]         i_req_offset,
    output logic      [1:0]          o_status,
    output logic      [2:0]          o_alloc_block,
    output logic      [15:0]         o_alloc_offset
);
    localparam int IW = bfasa_pkg::SEG_IW;
    localparam int BW = bfasa_pkg::BO_W;

    // latched request
    logic        r_type;
    logic [16:0] r_size;
    logic [4:0]  r_lg;
    logic [2:0]  r_blk;
    logic [15:0] r_off;

    logic [bfasa_pkg::MAX_SEGMENTS-1:0] r_valid;
    logic [IW:0]   r_nfree;
    logic [BW-1:0] r_opened;

    logic [IW-1:0] r_rd_idx;
    logic          r_ev;
    logic [IW-1:0] r_ev_idx;

    // scan findings
    logic          r_f0v, r_f1v;
    logic [IW-1:0] r_f0, r_f1;
    logic          r_bv;
    logic [IW-1:0] r_bidx;
    bfasa_pkg::t_seg r_bseg;
    logic [16:0]   r_bfront;
    logic          r_lv;
    logic [IW-1:0] r_lidx;
    bfasa_pkg::t_seg r_lseg;
    logic          r_rv;
    logic [IW-1:0] r_ridx;
    logic [16:0]   r_rlen;

    // update plan and result
    logic          r_w0_en, r_w1_en;
    logic [IW-1:0] r_w0_idx, r_w1_idx;
    bfasa_pkg::t_seg r_w0_seg, r_w1_seg;
    logic [1:0]    r_res_status;
    logic [2:0]    r_res_blk;
    logic [15:0]   r_res_off;

    bfasa_pkg::t_seg rd_seg;
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    bfasa_pkg::t_seg ram_wdata;

    assign ram_we    = (i_cmd.wr0 && r_w0_en) || (i_cmd.wr1 && r_w1_en);
    assign ram_waddr = i_cmd.wr0 ? r_w0_idx : r_w1_idx;
    assign ram_wdata = i_cmd.wr0 ? r_w0_seg : r_w1_seg;

    bfasa_ram #(
        .WIDTH ($bits(bfasa_pkg::t_seg)),
        .DEPTH (bfasa_pkg::MAX_SEGMENTS)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_seg)
    );

    assign o_stat.last_issued = (r_rd_idx == IW'(bfasa_pkg::MAX_SEGMENTS - 1));

    // evaluation of the entry whose read data is back
    logic        ev_v;
    logic [31:0] mask;
    logic [32:0] al, front;
    logic        fits, better, lc, rc;
    logic [17:0] req_end;

    always_comb begin
        ev_v    = r_valid[r_ev_idx];
        mask    = ~(32'hFFFF_FFFF << r_lg);
        al      = (33'(rd_seg.start) + 33'(mask)) & ~33'(mask);
        front   = al - 33'(rd_seg.start);
        fits    = (front <= 33'(rd_seg.len)) && (r_size <= (rd_seg.len - front[16:0]));
        better  = !r_bv || (rd_seg.len < r_bseg.len)
                || ((rd_seg.len == r_bseg.len) && ((rd_seg.blk < r_bseg.blk)
                || ((rd_seg.blk == r_bseg.blk) && (rd_seg.start < r_bseg.start))));
        req_end = 18'(r_off) + 18'(r_size);
        lc      = (18'(rd_seg.start) + 18'(rd_seg.len)) == 18'(r_off);
        rc      = 18'(rd_seg.start) == req_end;
    end

    // decision once the scan is complete
    logic          d_open, d_clr_en;
    logic [IW-1:0] d_clr_idx;
    logic          d_w0_en, d_w1_en;
    logic [IW-1:0] d_w0_idx, d_w1_idx;
    bfasa_pkg::t_seg d_w0_seg, d_w1_seg;
    logic [1:0]    d_status;
    logic [2:0]    d_blk;
    logic [15:0]   d_off;
    logic [16:0]   tail_fit, tail_new;
    logic [IW-1:0] slot_a, slot_b;
    logic          a_is_f0;

    always_comb begin
        d_open    = 1'b0;
        d_clr_en  = 1'b0;
        d_clr_idx = r_bidx;
        d_w0_en   = 1'b0;
        d_w1_en   = 1'b0;
        d_w0_idx  = r_f0;
        d_w1_idx  = r_f0;
        d_w0_seg  = '0;
        d_w1_seg  = '0;
        d_status  = bfasa_pkg::ST_OK;
        d_blk     = '0;
        d_off     = '0;
        tail_fit  = r_bseg.len - r_bfront - r_size;
        tail_new  = 17'(bfasa_pkg::BLOCK_BYTES) - r_size;
        // freed best entry joins the free slots; remainders go lowest first
        a_is_f0   = r_f0v && (r_f0 < r_bidx);
        slot_a    = a_is_f0 ? r_f0 : r_bidx;
        slot_b    = a_is_f0 ? ((r_f1v && (r_f1 < r_bidx)) ? r_f1 : r_bidx) : r_f0;
        if (r_type == bfasa_pkg::REQ_ALLOC) begin
            if ((r_size == '0) || (r_size > 17'(bfasa_pkg::BLOCK_BYTES))) begin
                d_status = bfasa_pkg::ST_TOO_LARGE;
            end else if (r_bv) begin
                if ((r_bfront != '0) && (tail_fit != '0) && (r_nfree == '0)) begin
                    d_status = bfasa_pkg::ST_TABLE_FULL;
                end else begin
                    d_clr_en = 1'b1;
                    d_w0_en  = r_bfront != '0;
                    d_w0_idx = slot_a;
                    d_w0_seg = '{blk: r_bseg.blk, start: r_bseg.start, len: r_bfront};
                    d_w1_en  = tail_fit != '0;
                    d_w1_idx = (r_bfront != '0) ? slot_b : slot_a;
                    d_w1_seg = '{blk: r_bseg.blk,
                                 start: r_bseg.start + r_bfront[15:0] + r_size[15:0],
                                 len: tail_fit};
                    d_blk    = r_bseg.blk;
                    d_off    = r_bseg.start + r_bfront[15:0];
                end
            end else if (r_opened >= BW'(bfasa_pkg::MAX_BLOCKS)) begin
                d_status = bfasa_pkg::ST_NO_BLOCK;
            end else if ((tail_new != '0) && (r_nfree == '0)) begin
                d_status = bfasa_pkg::ST_TABLE_FULL;
            end else begin
                d_open   = 1'b1;
                d_w1_en  = tail_new != '0;
                d_w1_idx = r_f0;
                d_w1_seg = '{blk: 3'(r_opened), start: r_size[15:0], len: tail_new};
                d_blk    = 3'(r_opened);
            end
        end else if ((r_size != '0) && (4'(r_blk) < 4'(r_opened))
                && (req_end <= 18'(bfasa_pkg::BLOCK_BYTES))) begin
            if (r_lv) begin
                d_w0_en  = 1'b1;
                d_w0_idx = r_lidx;
                d_w0_seg = '{blk: r_blk, start: r_lseg.start,
                             len: 17'(r_lseg.len + r_size + (r_rv ? r_rlen : 17'd0))};
                d_clr_en  = r_rv;
                d_clr_idx = r_ridx;
            end else if (r_rv) begin
                d_w0_en  = 1'b1;
                d_w0_idx = r_ridx;
                d_w0_seg = '{blk: r_blk, start: r_off, len: 17'(r_size + r_rlen)};
            end else if (r_nfree == '0) begin
                d_status = bfasa_pkg::ST_TABLE_FULL;
            end else begin
                d_w0_en  = 1'b1;
                d_w0_idx = r_f0;
                d_w0_seg = '{blk: r_blk, start: r_off, len: r_size};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_nfree  <= (IW + 1)'(bfasa_pkg::MAX_SEGMENTS);
            r_opened <= '0;
            r_ev     <= 1'b0;
            r_rd_idx <= '0;
        end else begin
            r_ev     <= i_cmd.scan;
            r_ev_idx <= r_rd_idx;
            if (i_cmd.load) begin
                r_type   <= i_req_type;
                r_size   <= i_req_size;
                r_lg     <= i_req_align_log2;
                r_blk    <= i_req_block;
                r_off    <= i_req_offset;
                r_rd_idx <= '0;
                r_f0v    <= 1'b0;
                r_f1v    <= 1'b0;
                r_bv     <= 1'b0;
                r_lv     <= 1'b0;
                r_rv     <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_ev) begin
                if (!ev_v) begin
                    if (!r_f0v) begin
                        r_f0v <= 1'b1;
                        r_f0  <= r_ev_idx;
                    end else if (!r_f1v) begin
                        r_f1v <= 1'b1;
                        r_f1  <= r_ev_idx;
                    end
                end else if (r_type == bfasa_pkg::REQ_ALLOC) begin
                    if (fits && better) begin
                        r_bv     <= 1'b1;
                        r_bidx   <= r_ev_idx;
                        r_bseg   <= rd_seg;
                        r_bfront <= front[16:0];
                    end
                end else if (rd_seg.blk == r_blk) begin
                    if (!r_lv && lc) begin
                        r_lv   <= 1'b1;
                        r_lidx <= r_ev_idx;
                        r_lseg <= rd_seg;
                    end else if (!r_rv && rc) begin
                        r_rv   <= 1'b1;
                        r_ridx <= r_ev_idx;
                        r_rlen <= rd_seg.len;
                    end
                end
            end
            if (i_cmd.decide) begin
                r_w0_en      <= d_w0_en;
                r_w0_idx     <= d_w0_idx;
                r_w0_seg     <= d_w0_seg;
                r_w1_en      <= d_w1_en;
                r_w1_idx     <= d_w1_idx;
                r_w1_seg     <= d_w1_seg;
                r_res_status <= d_status;
                r_res_blk    <= d_blk;
                r_res_off    <= d_off;
                if (d_open) begin
                    r_opened <= r_opened + 1'b1;
                end
                if (d_clr_en) begin
                    r_valid[d_clr_idx] <= 1'b0;
                    r_nfree            <= r_nfree + 1'b1;
                end
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
                if (!r_valid[ram_waddr]) begin
                    r_nfree <= r_nfree - 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                o_status       <= r_res_status;
                o_alloc_block  <= r_res_blk;
                o_alloc_offset <= r_res_off;
            end
        end
    end

    `BFASA_ASSERT(a_nfree_matches, i_clk, i_rst_n,
        r_nfree == (IW + 1)'($countones(~r_valid)), "free count out of step with valid bits")
    `BFASA_ASSERT(a_opened_bound, i_clk, i_rst_n,
        r_opened <= BW'(bfasa_pkg::MAX_BLOCKS), "too many blocks opened")
    `BFASA_ASSERT(a_write_sets_valid, i_clk, i_rst_n,
        ram_we |=> r_valid[$past(ram_waddr)], "written entry not marked valid")
endmodule
`default_nettype wire

@@ hdl/bfasa_ctrl.sv @@
// ----------------------------------------------------------------------------
// allocator controller
// sequences load, table scan, decision, table writes and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "best_fit_aligned_segment_allocator_assert.svh"
module bfasa_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire bfasa_pkg::t_stat i_stat,
    output bfasa_pkg::t_cmd       o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_WR0, S_WR1, S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_valid;
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.decide   = (r_state == S_DECIDE);
        o_cmd.wr0      = (r_state == S_WR0);
        o_cmd.wr1      = (r_state == S_WR1);
        o_cmd.out_load = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_stat.last_issued) r_state <= S_DRAIN;
                end
                S_DRAIN:  r_state <= S_DECIDE;
                S_DECIDE: r_state <= S_WR0;
                S_WR0:    r_state <= S_WR1;
                S_WR1:    r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    `BFASA_ASSERT(a_accept_starts_scan, i_clk, i_rst_n,
        (i_valid && o_ready) |=> (r_state == S_SCAN), "request accepted without scan")
    `BFASA_ASSERT(a_load_shows_result, i_clk, i_rst_n,
        o_cmd.out_load |=> r_out_valid, "loaded result not presented")
    `BFASA_ASSERT_IMP(a_scan_only_in_scan, i_clk, i_rst_n,
        o_cmd.scan, !r_out_valid || (r_state == S_SCAN), "scan outside scan state")
endmodule
`default_nettype wire

@@ hdl/best_fit_aligned_segment_allocator.sv @@
// ----------------------------------------------------------------------------
// best-fit aligned segment allocator
// best-fit allocate and coalescing free over a table of free segments
// ----------------------------------------------------------------------------
// Each request, from acceptance until its result is loaded, passes through a
// scan of every table entry through the single read port of the segment ram,
// then drain, decide, the two table writes and the result hand-off. One
// request is handled at a time, so a new request is not taken until the
// last one has finished; the result waits in an output register, and the
// next request is taken once that result has moved into it. The
// free-segment table needs no clearing pass after reset.
`default_nettype none
module best_fit_aligned_segment_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_req_type,
    input  wire logic [16:0] i_req_size,
    input  wire logic [4:0]  i_req_align_log2,
    input  wire logic [2:0]  i_req_block,
    input  wire logic [15:0] i_req_offset,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [2:0]       o_alloc_block,
    output logic [15:0]      o_alloc_offset
);
    bfasa_pkg::t_cmd  cmd;
    bfasa_pkg::t_stat stat;

    bfasa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    bfasa_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req_type),
        .i_req_size       (i_req_size),
        .i_req_align_log2 (i_req_align_log2),
        .i_req_block      (i_req_block),
        .i_req_offset     (i_req_offset),
        .o_status         (o_status),
        .o_alloc_block    (o_alloc_block),
        .o_alloc_offset   (o_alloc_offset)
    );
endmodule
`default_nettype wire
